### hw/rtl/stuf_pkg.sv
// Package: shared types and constants for the strip tile unpack/flip block.
package stuf_pkg;

    localparam int STRIP_SLOTS     = 1024;
    localparam int WORDS_PER_STRIP = 8;
    localparam int OUT_WORDS       = 16;
    localparam int STRIP_W         = $clog2(STRIP_SLOTS);
    localparam int WSEL_W          = $clog2(WORDS_PER_STRIP);
    localparam int POS_W           = $clog2(OUT_WORDS);
    localparam int STORE_DEPTH     = STRIP_SLOTS * WORDS_PER_STRIP;
    localparam int STORE_AW        = STRIP_W + WSEL_W;
    localparam int Q_DEPTH         = 2;
    localparam int Q_PTR_W         = $clog2(Q_DEPTH);
    localparam int Q_CNT_W         = $clog2(Q_DEPTH + 1);

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(OUT_WORDS - 1);

    localparam logic [31:0] LO_NIB_MASK = 32'h0F0F_0F0F;
    localparam logic [31:0] HI_NIB_MASK = 32'hF0F0_F0F0;
    localparam logic [31:0] HI_HALF     = 32'hFFFF_0000;
    localparam logic [31:0] LO_HALF     = 32'h0000_FFFF;
    localparam logic [31:0] HI_BYTES    = 32'hFF00_FF00;
    localparam logic [31:0] LO_BYTES    = 32'h00FF_00FF;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_EMIT = 1'b1
    } t_cmd;

    typedef struct packed {
        logic        cmd;
        logic [12:0] load_addr;
        logic [31:0] load_data;
        logic [9:0]  strip_index;
        logic        flip;
        logic        final_strip;
    } t_item;

    typedef struct packed {
        logic [31:0] pixel_word;
        logic [3:0]  word_pos;
        logic        strip_end;
        logic        image_end;
    } t_result;

    // Classified work handed from front to back.
    typedef struct packed {
        t_cmd                cmd;
        logic [STORE_AW-1:0] addr;
        logic [31:0]         data;
        logic [STRIP_W-1:0]  strip;
        logic                mirror;
        logic                fin;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

### hw/rtl/stuf_front.sv
// Front end: takes commands, holds mode and sequence counter, builds jobs.
module stuf_front import stuf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_item   i_item,
    input  logic    i_cfg_valid,
    input  logic    i_cfg_data,
    input  t_q_stat i_q_stat,
    output logic    o_busy,
    output logic    o_push,
    output t_job    o_job
);

    logic               r_mapped, n_mapped;
    logic [STRIP_W-1:0] r_seq, n_seq;
    logic               accept;

    assign o_busy = i_q_stat.full;
    assign accept = i_start && !i_q_stat.full;
    assign o_push = accept;

    always_comb begin
        o_job.cmd    = t_cmd'(i_item.cmd);
        o_job.addr   = STORE_AW'(i_item.load_addr);
        o_job.data   = i_item.load_data;
        o_job.strip  = r_mapped ? i_item.strip_index[STRIP_W-1:0] : r_seq;
        o_job.mirror = r_mapped && i_item.flip;
        o_job.fin    = i_item.final_strip;
    end

    always_comb begin
        n_mapped = i_cfg_valid ? i_cfg_data : r_mapped;
        n_seq    = r_seq;
        if (accept && o_job.cmd == CMD_EMIT) begin
            if (i_item.final_strip) begin
                n_seq = '0;
            end else if (!r_mapped) begin
                n_seq = r_seq + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mapped <= 1'b1;
            r_seq    <= '0;
        end else begin
            r_mapped <= n_mapped;
            r_seq    <= n_seq;
        end
    end

endmodule

### hw/rtl/stuf_queue.sv
// Small job queue between front and back.
module stuf_queue import stuf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_job,
    input  logic    i_pop,
    output t_job    o_head,
    output t_q_stat o_stat
);

    t_job                r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr, n_wr;
    logic [Q_PTR_W-1:0]  r_rd, n_rd;
    logic [Q_CNT_W-1:0]  r_cnt, n_cnt;

    assign o_stat.full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_head       = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

### hw/rtl/stuf_back.sv
// Back end: strip store, word sequencer and nibble expansion.
module stuf_back import stuf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_job    i_head,
    input  t_q_stat i_q_stat,
    output logic    o_pop,
    output logic    o_res_valid,
    output t_result o_res
);

    logic [31:0]         r_store [STORE_DEPTH];

    logic                r_busy, n_busy;
    logic [POS_W-1:0]    r_cnt, n_cnt;
    logic [STRIP_W-1:0]  r_strip;
    logic                r_mirror;
    logic                r_fin;

    logic                r_s1_valid;
    logic [POS_W-1:0]    r_s1_pos;
    logic                r_s1_odd;
    logic                r_s1_mirror;
    logic                r_s1_fin;
    logic [31:0]         r_rd_data;

    logic                r_out_valid;
    t_result             r_out;

    logic [STORE_AW-1:0] rd_addr;
    logic [WSEL_W-1:0]   wsel;
    logic                odd;
    logic [31:0]         expanded;
    logic                last;

    function automatic logic [31:0] byte_rev(input logic [31:0] v);
        logic [31:0] t;
        t = ((v & HI_HALF) >> 16) | ((v & LO_HALF) << 16);
        t = ((t & HI_BYTES) >> 8) | ((t & LO_BYTES) << 8);
        return t;
    endfunction

    assign last  = r_busy && (r_cnt == LAST_POS);
    assign o_pop = !i_q_stat.empty && (!r_busy || last);

    // mirrored strip walks source positions backward
    always_comb begin
        wsel    = r_mirror ? ~r_cnt[POS_W-1:1] : r_cnt[POS_W-1:1];
        odd     = r_mirror ? ~r_cnt[0] : r_cnt[0];
        rd_addr = {r_strip, wsel};
    end

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        if (r_busy) begin
            n_cnt = r_cnt + 1'b1;
            if (last) begin
                n_busy = 1'b0;
            end
        end
        if (o_pop && i_head.cmd == CMD_EMIT) begin
            n_busy = 1'b1;
            n_cnt  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_cnt       <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_cnt       <= n_cnt;
            r_s1_valid  <= r_busy;
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_head.cmd == CMD_EMIT) begin
            r_strip  <= i_head.strip;
            r_mirror <= i_head.mirror;
            r_fin    <= i_head.fin;
        end
        r_s1_pos    <= r_cnt;
        r_s1_odd    <= odd;
        r_s1_mirror <= r_mirror;
        r_s1_fin    <= r_fin;
    end

    // store: one write port for loads, one registered read port for emits
    always_ff @(posedge i_clk) begin
        if (o_pop && i_head.cmd == CMD_LOAD) begin
            r_store[i_head.addr] <= i_head.data;
        end
        if (r_busy) begin
            r_rd_data <= r_store[rd_addr];
        end
    end

    always_comb begin
        expanded = r_s1_odd ? ((r_rd_data & HI_NIB_MASK) >> 4) : (r_rd_data & LO_NIB_MASK);
        if (r_s1_mirror) begin
            expanded = byte_rev(expanded);
        end
    end

    always_ff @(posedge i_clk) begin
        r_out.pixel_word <= expanded;
        r_out.word_pos   <= 4'(r_s1_pos);
        r_out.strip_end  <= (r_s1_pos == LAST_POS);
        r_out.image_end  <= (r_s1_pos == LAST_POS) && r_s1_fin;
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    a_cnt_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !last) |=> (r_busy && r_cnt == $past(r_cnt) + 1'b1))
        else $error("word sequencer skipped or stalled mid strip");

    a_pop_only_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (!r_busy || r_cnt == LAST_POS))
        else $error("job taken while strip still in progress");

    a_out_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> ##1 o_res_valid)
        else $error("issued read did not reach output");

    a_end_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.image_end) |-> (o_res.strip_end && o_res.word_pos == 4'hF))
        else $error("image end outside last word of strip");

endmodule

### hw/rtl/strip_tile_unpack_flip.sv
// Top level: 4-bpp strip store with 8-bit pixel expansion and horizontal flip.
// An emit accepted with the queue empty and the back end free passes the queue,
//   sequencer, store read and output registers before its first word is given.
// Each emit reads the store once per output word, and loads produce no result
//   beats; a two-entry job queue lets commands be taken while a strip streams.
// Reset (sync, active low) clears mode to mapped, sequence counter, queue and
//   sequencer; the strip store is not cleared. Results cannot be stalled.
module strip_tile_unpack_flip import stuf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    // command channel
    input  logic    start,
    output logic    busy,
    input  t_item   i_item,
    // mode register write channel
    input  logic    i_cfg_valid,
    output logic    o_cfg_ready,
    input  logic    i_cfg_data,
    // result beats, one per cycle while strobed
    output logic    o_res_valid,
    output t_result o_res
);

    t_q_stat q_stat;
    logic    push;
    logic    pop;
    t_job    job_in;
    t_job    job_head;

    // mode register always takes writes
    assign o_cfg_ready = 1'b1;

    // front: mode, sequence counter, strip/mirror resolved at acceptance
    stuf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_item      (i_item),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_q_stat    (q_stat),
        .o_busy      (busy),
        .o_push      (push),
        .o_job       (job_in)
    );

    // loads and emits stay in order through the queue, so a load after an
    // emit never lands before that emit has read its strip
    stuf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_head  (job_head),
        .o_stat  (q_stat)
    );

    // back: store writes, per-word reads, expand/flip, output register
    stuf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (job_head),
        .i_q_stat    (q_stat),
        .o_pop       (pop),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

endmodule
